// ===== src/dfcc_pkg.sv =====
// Package for the disk footprint collision check: defaults, codes, states and helpers.
package dfcc_pkg;

   // Default geometry
   localparam int GRID_W_DEF = 256;
   localparam int GRID_H_DEF = 256;
   localparam int RADIUS_DEF = 4;

   // Radius is to be kept at most 31 by the user, unchecked here, so a half width fits in five bits
   localparam int RAD_W = 5;

   // Control and status register indexes
   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_X_OFFSET = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_OFFSET = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_X_SCALE  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_SCALE  = 8'd3;

   // Register reset values (offsets Q16.16, scales Q8.16)
   localparam logic [31:0] X_OFFSET_RST = 32'd983040;
   localparam logic [31:0] Y_OFFSET_RST = 32'd578683;
   localparam logic [23:0] X_SCALE_RST  = 24'd559241;
   localparam logic [23:0] Y_SCALE_RST  = 24'd495925;

   // Command carried in the request tuser
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [1:0] {
      STAT_CLEAR      = 2'd0,
      STAT_CENTRE_OFF = 2'd1,
      STAT_FOOT_OFF   = 2'd2,
      STAT_OBSTACLE   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE,
      ST_MAG,
      ST_MUL,
      ST_CELL,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // Largest w with w*w + dy*dy <= r*r; used on constants only
   function automatic int half_width(input int r, input int dy);
      int w;
      w = 0;
      for (int k = 0; k <= 31; k++) begin
         if ((k * k + dy * dy) <= r * r) begin
            w = k;
         end
      end
      return w;
   endfunction

endpackage

// ===== src/dfcc_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module dfcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/disk_footprint_collision_check.sv =====
// Top level of the disk footprint collision check on a one-bit occupancy grid.
// Query steps: idle, magnitude, multiply, cell, row scan, drain and finish, where the result
//   is loaded onto rsp once rsp is free; when the centre or the footprint lies off the map
//   the cell step goes straight to finish. A map write reads its row in idle and writes it
//   back in the write step. Words are taken only in idle; the scan reads one grid row per
//   cycle through the single map read port. Reset: synchronous; control registers return
//   to defaults, then a clearing pass blocks every cell, during which no word is taken.
module disk_footprint_collision_check #(
   parameter int GRID_W = dfcc_pkg::GRID_W_DEF,
   parameter int GRID_H = dfcc_pkg::GRID_H_DEF,
   parameter int RADIUS = dfcc_pkg::RADIUS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [7:0] cell_col, [15:8] cell_row, [16] cell_free, [48:17] pos_x, [80:49] pos_y, rest zero
   input  logic [87:0]                     req_tdata,
   // [0] cmd
   input  logic                            req_tuser,
   // result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] position_clear, [2:1] status, rest zero
   output logic [7:0]                      rsp_tdata,
   // register write port
   input  logic                            csr_wr_en,
   input  logic [dfcc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]                     csr_wr_data
);

   localparam int COL_W = $clog2(GRID_W);
   localparam int ROW_W = $clog2(GRID_H);
   localparam int ROWS  = 2 * RADIUS + 1;              // grid rows spanned by the disk
   localparam int IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;

   // ---------------------------------------------------------------------------------
   // Request word fields
   // ---------------------------------------------------------------------------------
   logic [7:0]  req_col;
   logic [7:0]  req_row;
   logic        req_free;
   logic [31:0] req_pos_x;
   logic [31:0] req_pos_y;
   logic        req_acc;
   logic        wr_in_range;

   assign req_col   = req_tdata[7:0];
   assign req_row   = req_tdata[15:8];
   assign req_free  = req_tdata[16];
   assign req_pos_x = req_tdata[48:17];
   assign req_pos_y = req_tdata[80:49];
   assign req_acc   = req_tvalid && req_tready;

   // writes beyond the grid are dropped
   assign wr_in_range = (32'(req_col) < 32'(GRID_W)) && (32'(req_row) < 32'(GRID_H));

   // ---------------------------------------------------------------------------------
   // State
   // ---------------------------------------------------------------------------------
   dfcc_pkg::state_type  state_ff, state_in;

   logic [31:0]          x_off_ff, y_off_ff;
   logic [23:0]          x_scl_ff, y_scl_ff;

   logic signed [32:0]   sum_x_ff, sum_y_ff;      // position + offset, exact
   logic [32:0]          mag_x_ff, mag_y_ff;      // magnitude of the sums
   logic                 neg_x_ff, neg_y_ff;
   logic [56:0]          prod_x_ff, prod_y_ff;    // Q25.32 magnitude products
   logic                 pneg_x_ff, pneg_y_ff;

   logic [COL_W-1:0]     cx_ff;
   logic [ROW_W-1:0]     cy_ff;
   dfcc_pkg::status_type stat_ff;
   logic                 hit_ff;

   logic [IDX_W-1:0]     issue_cnt_ff;
   logic                 chk_vld_ff;
   logic [IDX_W-1:0]     chk_idx_ff;

   logic [ROW_W-1:0]     clr_cnt_ff;

   logic [COL_W-1:0]     wr_col_ff;
   logic [ROW_W-1:0]     wr_row_ff;
   logic                 wr_free_ff;

   logic                 rsp_tvalid_ff;
   logic                 rsp_clear_ff;
   dfcc_pkg::status_type rsp_status_ff;

   // ---------------------------------------------------------------------------------
   // Map memory: one row of GRID_W cells per entry
   // ---------------------------------------------------------------------------------
   logic              ram_wr_en;
   logic [ROW_W-1:0]  ram_wr_addr;
   logic [GRID_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [ROW_W-1:0]  ram_rd_addr;
   logic [GRID_W-1:0] ram_rd_data;

   dfcc_ram #(
      .WIDTH (GRID_W),
      .DEPTH (GRID_H)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------------------------
   // Cell mapping
   // ---------------------------------------------------------------------------------
   logic [24:0] whole_x, whole_y;
   logic        ctr_ok, foot_off;

   assign whole_x = prod_x_ff[56:32];
   assign whole_y = prod_y_ff[56:32];

   // a negative product that truncates to zero still lands on cell zero
   assign ctr_ok = !(pneg_x_ff && (whole_x != 25'd0)) && (32'(whole_x) < 32'(GRID_W))
                && !(pneg_y_ff && (whole_y != 25'd0)) && (32'(whole_y) < 32'(GRID_H));

   // the disk reaches RADIUS cells each way, along both axes
   assign foot_off = (32'(whole_x) < 32'(RADIUS)) || (32'(whole_x) + 32'(RADIUS) >= 32'(GRID_W))
                  || (32'(whole_y) < 32'(RADIUS))
                  || (32'(whole_y) + 32'(RADIUS) >= 32'(GRID_H));

   // ---------------------------------------------------------------------------------
   // Row check: half width of the disk for each scanned row
   // ---------------------------------------------------------------------------------
   logic [dfcc_pkg::RAD_W-1:0] hw_tab [ROWS];

   for (genvar k = 0; k < ROWS; k++) begin : g_hw
      assign hw_tab[k] = dfcc_pkg::RAD_W'(dfcc_pkg::half_width(RADIUS, k - RADIUS));
   end

   logic [COL_W:0]    win_lo, win_hi;
   logic [GRID_W-1:0] win_mask;
   logic              row_hit;

   // footprint is known to be on the map here, so the window stays in range
   assign win_lo = (COL_W + 1)'(cx_ff) - (COL_W + 1)'(hw_tab[chk_idx_ff]);
   assign win_hi = (COL_W + 1)'(cx_ff) + (COL_W + 1)'(hw_tab[chk_idx_ff]);

   always_comb begin
      for (int i = 0; i < GRID_W; i++) begin
         win_mask[i] = ((COL_W + 1)'(i) >= win_lo) && ((COL_W + 1)'(i) <= win_hi);
      end
   end

   assign row_hit = |(win_mask & ~ram_rd_data);

   // ---------------------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dfcc_pkg::ST_CLEAR: begin
            if (32'(clr_cnt_ff) == 32'(GRID_H - 1)) begin
               state_in = dfcc_pkg::ST_IDLE;
            end
         end
         dfcc_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (req_tuser == dfcc_pkg::CMD_QUERY) begin
                  state_in = dfcc_pkg::ST_MAG;
               end else if (wr_in_range) begin
                  state_in = dfcc_pkg::ST_WRITE;
               end
            end
         end
         dfcc_pkg::ST_WRITE: state_in = dfcc_pkg::ST_IDLE;
         dfcc_pkg::ST_MAG:   state_in = dfcc_pkg::ST_MUL;
         dfcc_pkg::ST_MUL:   state_in = dfcc_pkg::ST_CELL;
         dfcc_pkg::ST_CELL: begin
            state_in = (ctr_ok && !foot_off) ? dfcc_pkg::ST_SCAN : dfcc_pkg::ST_FINISH;
         end
         dfcc_pkg::ST_SCAN: begin
            if (issue_cnt_ff == IDX_W'(ROWS - 1)) begin
               state_in = dfcc_pkg::ST_DRAIN;
            end
         end
         dfcc_pkg::ST_DRAIN: state_in = dfcc_pkg::ST_FINISH;
         dfcc_pkg::ST_FINISH: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               state_in = dfcc_pkg::ST_IDLE;
            end
         end
         default: state_in = dfcc_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------------------
   // Outputs of the sequencer
   // ---------------------------------------------------------------------------------
   logic              rsp_load;
   logic [GRID_W-1:0] wr_row_data;

   always_comb begin
      wr_row_data            = ram_rd_data;
      wr_row_data[wr_col_ff] = wr_free_ff;
   end

   always_comb begin
      req_tready  = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = wr_row_ff;
      ram_wr_data = wr_row_data;
      ram_rd_en   = 1'b0;
      ram_rd_addr = ROW_W'(32'(cy_ff) + 32'(issue_cnt_ff) - 32'(RADIUS));
      rsp_load    = 1'b0;
      unique case (state_ff)
         dfcc_pkg::ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_ff;
            ram_wr_data = '0;
         end
         dfcc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            // fetch the row for a read-modify-write of one cell
            ram_rd_en   = req_tvalid && (req_tuser == dfcc_pkg::CMD_WRITE) && wr_in_range;
            ram_rd_addr = ROW_W'(req_row);
         end
         dfcc_pkg::ST_WRITE: ram_wr_en = 1'b1;
         dfcc_pkg::ST_SCAN:  ram_rd_en = 1'b1;
         dfcc_pkg::ST_FINISH: rsp_load = !rsp_tvalid_ff || rsp_tready;
         default: ;
      endcase
   end

   // ---------------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dfcc_pkg::ST_CLEAR;
         clr_cnt_ff    <= '0;
         chk_vld_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         x_off_ff      <= dfcc_pkg::X_OFFSET_RST;
         y_off_ff      <= dfcc_pkg::Y_OFFSET_RST;
         x_scl_ff      <= dfcc_pkg::X_SCALE_RST;
         y_scl_ff      <= dfcc_pkg::Y_SCALE_RST;
      end else begin
         state_ff   <= state_in;
         chk_vld_ff <= (state_ff == dfcc_pkg::ST_SCAN);
         if (state_ff == dfcc_pkg::ST_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + ROW_W'(1);
         end
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            unique case (csr_index)
               dfcc_pkg::CSR_X_OFFSET: x_off_ff <= csr_wr_data;
               dfcc_pkg::CSR_Y_OFFSET: y_off_ff <= csr_wr_data;
               dfcc_pkg::CSR_X_SCALE:  x_scl_ff <= csr_wr_data[23:0];
               dfcc_pkg::CSR_Y_SCALE:  y_scl_ff <= csr_wr_data[23:0];
               default: ;
            endcase
         end
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      if (req_acc) begin
         sum_x_ff   <= $signed({req_pos_x[31], req_pos_x}) + $signed({x_off_ff[31], x_off_ff});
         sum_y_ff   <= $signed({req_pos_y[31], req_pos_y}) + $signed({y_off_ff[31], y_off_ff});
         wr_col_ff  <= COL_W'(req_col);
         wr_row_ff  <= ROW_W'(req_row);
         wr_free_ff <= req_free;
      end

      if (state_ff == dfcc_pkg::ST_MAG) begin
         neg_x_ff <= sum_x_ff[32];
         neg_y_ff <= sum_y_ff[32];
         mag_x_ff <= sum_x_ff[32] ? 33'(-sum_x_ff) : 33'(sum_x_ff);
         mag_y_ff <= sum_y_ff[32] ? 33'(-sum_y_ff) : 33'(sum_y_ff);
      end

      if (state_ff == dfcc_pkg::ST_MUL) begin
         prod_x_ff <= 57'(mag_x_ff) * 57'(x_scl_ff);
         prod_y_ff <= 57'(mag_y_ff) * 57'(y_scl_ff);
         pneg_x_ff <= neg_x_ff;
         pneg_y_ff <= neg_y_ff;
      end

      if (state_ff == dfcc_pkg::ST_CELL) begin
         cx_ff        <= whole_x[COL_W-1:0];
         cy_ff        <= whole_y[ROW_W-1:0];
         hit_ff       <= 1'b0;
         issue_cnt_ff <= '0;
         if (!ctr_ok) begin
            stat_ff <= dfcc_pkg::STAT_CENTRE_OFF;
         end else if (foot_off) begin
            stat_ff <= dfcc_pkg::STAT_FOOT_OFF;
         end else begin
            stat_ff <= dfcc_pkg::STAT_CLEAR;
         end
      end

      if (state_ff == dfcc_pkg::ST_SCAN) begin
         issue_cnt_ff <= issue_cnt_ff + IDX_W'(1);
      end
      chk_idx_ff <= issue_cnt_ff;

      // row data comes from the registered read port in the cycle after its read
      if (chk_vld_ff) begin
         hit_ff <= hit_ff | row_hit;
      end

      if (rsp_load) begin
         if ((stat_ff == dfcc_pkg::STAT_CLEAR) && hit_ff) begin
            rsp_status_ff <= dfcc_pkg::STAT_OBSTACLE;
            rsp_clear_ff  <= 1'b0;
         end else begin
            rsp_status_ff <= stat_ff;
            rsp_clear_ff  <= (stat_ff == dfcc_pkg::STAT_CLEAR);
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {5'b0, rsp_status_ff, rsp_clear_ff};

   // ---------------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------------
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == dfcc_pkg::ST_FINISH))
      else $error("result word raised outside the finish step");

   a_clear_matches_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> (rsp_clear_ff == (rsp_status_ff == dfcc_pkg::STAT_CLEAR)))
      else $error("pass flag disagrees with status");

   a_no_port_clash: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("map read and write in the same cycle");

   a_check_in_scan: assert property (@(posedge clock) disable iff (reset)
      chk_vld_ff |-> (state_ff == dfcc_pkg::ST_SCAN || state_ff == dfcc_pkg::ST_DRAIN))
      else $error("row check outside the scan");

endmodule

// ===== tb/sv/disk_footprint_collision_check_tb.sv =====
// Testbench for the disk footprint collision check: own map model, scoreboard and stream drivers.
`timescale 1ns / 1ps

module disk_footprint_collision_check_tb;

   // Geometry of the block as built with its default parameters
   localparam int GRID_W        = dfcc_pkg::GRID_W_DEF;
   localparam int GRID_H        = dfcc_pkg::GRID_H_DEF;
   localparam int GRID_CELLS    = GRID_W * GRID_H;
   localparam int FOOT_R        = dfcc_pkg::RADIUS_DEF;
   // Longest query latency plus margin; used before register writes and at the end
   localparam int SETTLE_CYCLES = 2 * FOOT_R + 10;
   // Cycle limit for the run; the bench reports failure when it is reached
   localparam int CYCLE_LIMIT   = 900_000;

   // Register indexes that decode to nothing
   localparam logic [dfcc_pkg::CSR_IDX_W-1:0] CSR_NONE_LO = dfcc_pkg::CSR_Y_SCALE + 8'd1;
   localparam logic [dfcc_pkg::CSR_IDX_W-1:0] CSR_NONE_HI = '1;

   localparam longint POS_MAX = 64'sd2147483647;
   localparam longint POS_MIN = -64'sd2147483648;

   typedef struct packed {
      logic                 clear;
      dfcc_pkg::status_type status;
   } verdict_type;

   // Map and register copy, plus the queue of verdicts still owed by the block
   class footprint_verdicts;
      bit                 free_cells [GRID_CELLS];
      logic signed [31:0] x_off, y_off;
      logic [23:0]        x_scale, y_scale;
      verdict_type        awaited_verdicts [$];
      int                 errors;

      function new();
         x_off   = dfcc_pkg::X_OFFSET_RST;
         y_off   = dfcc_pkg::Y_OFFSET_RST;
         x_scale = dfcc_pkg::X_SCALE_RST;
         y_scale = dfcc_pkg::Y_SCALE_RST;
         errors  = 0;
      endfunction

      function void set_register(logic [dfcc_pkg::CSR_IDX_W-1:0] idx, logic [31:0] value);
         case (idx)
            dfcc_pkg::CSR_X_OFFSET: x_off   = value;
            dfcc_pkg::CSR_Y_OFFSET: y_off   = value;
            dfcc_pkg::CSR_X_SCALE:  x_scale = value[23:0];
            dfcc_pkg::CSR_Y_SCALE:  y_scale = value[23:0];
            default: ;
         endcase
      endfunction

      // (pos + off) * scale in Q32.32, integer part truncated toward zero
      function longint grid_index(logic signed [31:0] pos, logic signed [31:0] off,
                                  logic [23:0] scale);
         longint          sum;
         longint unsigned mag, whole;
         sum   = longint'(pos) + longint'(off);
         mag   = (sum < 0) ? -sum : sum;
         whole = (mag * {40'd0, scale}) >> 32;
         return (sum < 0) ? -longint'(whole) : longint'(whole);
      endfunction

      function verdict_type judge_position(logic [31:0] pos_x, logic [31:0] pos_y);
         longint      cx, cy, nx, ny;
         bit          off_map, hit;
         verdict_type v;
         off_map = 0;
         hit     = 0;
         cx = grid_index(pos_x, x_off, x_scale);
         cy = grid_index(pos_y, y_off, y_scale);
         if (cx < 0 || cx >= GRID_W || cy < 0 || cy >= GRID_H) begin
            v.status = dfcc_pkg::STAT_CENTRE_OFF;
         end else begin
            for (int dy = -FOOT_R; dy <= FOOT_R; dy++) begin
               for (int dx = -FOOT_R; dx <= FOOT_R; dx++) begin
                  nx = cx + dx;
                  ny = cy + dy;
                  if (dx * dx + dy * dy <= FOOT_R * FOOT_R) begin
                     if (nx < 0 || nx >= GRID_W || ny < 0 || ny >= GRID_H)
                        off_map = 1;
                     else if (!free_cells[ny * GRID_W + nx])
                        hit = 1;
                  end
               end
            end
            // off-map wins over an obstacle
            v.status = off_map ? dfcc_pkg::STAT_FOOT_OFF
                               : (hit ? dfcc_pkg::STAT_OBSTACLE : dfcc_pkg::STAT_CLEAR);
         end
         v.clear = (v.status == dfcc_pkg::STAT_CLEAR);
         return v;
      endfunction

      function void note_word(logic cmd, logic [7:0] col, logic [7:0] row, logic free,
                              logic [31:0] pos_x, logic [31:0] pos_y);
         if (cmd == dfcc_pkg::CMD_WRITE) begin
            if (col < GRID_W && row < GRID_H)
               free_cells[int'(row) * GRID_W + int'(col)] = free;
         end else begin
            awaited_verdicts = {awaited_verdicts, judge_position(pos_x, pos_y)};
         end
      endfunction

      function void check_verdict(logic [7:0] data);
         verdict_type want;
         if (awaited_verdicts.size() == 0) begin
            $error("result word 0x%02h with no query outstanding", data);
            errors++;
            return;
         end
         want = awaited_verdicts.pop_front();
         if (data[0] !== want.clear) begin
            $error("position_clear: expected %0d, got %0d", want.clear, data[0]);
            errors++;
         end
         if (data[2:1] !== want.status) begin
            $error("status: expected %0d (%s), got %0d", want.status, want.status.name(),
                   data[2:1]);
            errors++;
         end
         if (data[7:3] !== 5'd0) begin
            $error("rsp_tdata pad: expected 0, got 0x%02h", data[7:3]);
            errors++;
         end
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [87:0]                    req_tdata;
   logic                           req_tuser;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [7:0]                     rsp_tdata;
   logic                           csr_wr_en;
   logic [dfcc_pkg::CSR_IDX_W-1:0] csr_index;
   logic [31:0]                    csr_wr_data;

   footprint_verdicts sb = new();
   int  words_sent = 0;
   int  cycles     = 0;
   int  last_col   = GRID_W / 2;
   int  last_row   = GRID_H / 2;
   // idle switches: sender gaps and receiver stalls
   bit  sender_idle = 0;
   bit  sink_stall  = 0;

   disk_footprint_collision_check dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("disk_footprint_collision_check test failed");
         $finish;
      end
   end

   // Result monitor: sampled at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_verdict(rsp_tdata);
   end

   // Mostly short gaps, now and then a long one
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Receiver: bursts of ready, stalls only while sink_stall is set
   initial begin
      rsp_tready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         repeat ($urandom_range(1, 24)) begin
            @(negedge clock);
            rsp_tready = 1'b1;
         end
         if (sink_stall) begin
            repeat (idle_length()) begin
               @(negedge clock);
               rsp_tready = 1'b0;
            end
         end
      end
   end

   // Position word that lands on grid index target under the given offset and scale.
   // Sum is rounded up to the next cell boundary, then jittered by up to half a cell.
   function automatic logic [31:0] pos_for_cell(int target, logic signed [31:0] off,
                                                logic [23:0] scale);
      longint sc, sum, jit_max, p;
      if (scale == 24'd0)
         return $urandom;
      sc      = longint'(scale);
      sum     = ((longint'(target) <<< 32) + sc - 1) / sc;
      jit_max = (64'sd1 <<< 31) / sc;
      if (jit_max > 65535) jit_max = 65535;
      sum = sum + longint'($urandom_range(0, int'(jit_max)));
      p   = sum - longint'(off);
      if (p > POS_MAX) p = POS_MAX;
      if (p < POS_MIN) p = POS_MIN;
      return p[31:0];
   endfunction

   // Centre coordinate: mostly with the whole disk on the map, sometimes at a border
   function automatic int pick_centre(int span);
      if ($urandom_range(0, 6) == 0)
         return $urandom_range(0, 1) ? $urandom_range(0, FOOT_R)
                                     : span - 1 - $urandom_range(0, FOOT_R);
      return $urandom_range(FOOT_R, span - 1 - FOOT_R);
   endfunction

   // Every driver task is entered and left just after a falling edge.
   task automatic send_word(logic cmd, logic [7:0] col, logic [7:0] row, logic free,
                            logic [31:0] pos_x, logic [31:0] pos_y);
      int gap;
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = {7'd0, pos_y, pos_x, free, row, col};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_word(cmd, col, row, free, pos_x, pos_y);
      words_sent++;
      @(negedge clock);
      gap = sender_idle ? idle_length() : 0;
      // with no gap the next word goes straight on, valid stays high
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic query_cell(int col, int row);
      send_word(dfcc_pkg::CMD_QUERY, 8'($urandom), 8'($urandom), 1'($urandom),
                pos_for_cell(col, sb.x_off, sb.x_scale),
                pos_for_cell(row, sb.y_off, sb.y_scale));
   endtask

   // Sender holds off until every verdict owed has come back
   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (sb.awaited_verdicts.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Drained and then long enough for a trailing map write to finish
   task automatic settle();
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(logic [dfcc_pkg::CSR_IDX_W-1:0] idx, logic [31:0] value);
      req_tvalid  = 1'b0;
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = value;
      sb.set_register(idx, value);
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   task automatic apply_config(logic [31:0] xo, logic [31:0] yo, logic [31:0] xs,
                               logic [31:0] ys);
      settle();
      write_register(dfcc_pkg::CSR_X_OFFSET, xo);
      write_register(dfcc_pkg::CSR_Y_OFFSET, yo);
      write_register(dfcc_pkg::CSR_X_SCALE, xs);
      write_register(dfcc_pkg::CSR_Y_SCALE, ys);
   endtask

   // Free every disk cell around a centre in shuffled order, optionally one left blocked
   task automatic paint_disk(int col, int row, bit flaw);
      int cols [$];
      int rows [$];
      int n, j, t, flaw_at;
      for (int dy = -FOOT_R; dy <= FOOT_R; dy++) begin
         for (int dx = -FOOT_R; dx <= FOOT_R; dx++) begin
            if (dx * dx + dy * dy <= FOOT_R * FOOT_R && col + dx >= 0 && col + dx < GRID_W
                && row + dy >= 0 && row + dy < GRID_H) begin
               cols = {cols, col + dx};
               rows = {rows, row + dy};
            end
         end
      end
      n = cols.size();
      for (int i = n - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = cols[i]; cols[i] = cols[j]; cols[j] = t;
         t = rows[i]; rows[i] = rows[j]; rows[j] = t;
      end
      flaw_at = flaw ? $urandom_range(0, n - 1) : -1;
      for (int i = 0; i < n; i++)
         send_word(dfcc_pkg::CMD_WRITE, 8'(cols[i]), 8'(rows[i]), i != flaw_at,
                   $urandom, $urandom);
      last_col = col;
      last_row = row;
   endtask

   // Random traffic: mostly paint-then-query sequences, the rest noise
   task automatic run_phase(int budget);
      int stop, r, col, row, dc;
      stop = words_sent + budget;
      while (words_sent < stop) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            col = pick_centre(GRID_W);
            row = pick_centre(GRID_H);
            paint_disk(col, row, $urandom_range(0, 3) == 0);
            query_cell(col, row);
            // neighbours overlap unpainted ground, usually an obstacle
            repeat ($urandom_range(0, 2)) begin
               col = last_col + $urandom_range(0, 4) - 2;
               row = last_row + $urandom_range(0, 4) - 2;
               query_cell(col < 0 ? 0 : col, row < 0 ? 0 : row);
            end
            if ($urandom_range(0, 19) == 0)
               wait_drained();
         end else if (r < 80) begin
            send_word(dfcc_pkg::CMD_WRITE, 8'($urandom), 8'($urandom), 1'($urandom),
                      $urandom, $urandom);
         end else if (r < 88) begin
            query_cell($urandom_range(0, GRID_W - 1), $urandom_range(0, GRID_H - 1));
         end else if (r < 95) begin
            send_word(dfcc_pkg::CMD_QUERY, 8'($urandom), 8'($urandom), 1'($urandom),
                      $urandom, $urandom);
         end else begin
            // block one cell on the last painted disk, then ask again
            dc = last_col + $urandom_range(0, 2 * FOOT_R) - FOOT_R;
            if (dc >= 0 && dc < GRID_W)
               send_word(dfcc_pkg::CMD_WRITE, 8'(dc), 8'(last_row), 1'b0,
                         $urandom, $urandom);
            query_cell(last_col, last_row);
         end
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tuser   = dfcc_pkg::CMD_WRITE;
      req_tdata   = '0;
      csr_wr_en   = 1'b0;
      csr_index   = dfcc_pkg::CSR_X_OFFSET;
      csr_wr_data = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: reset registers, whole map blocked apart from a few cells
      send_word(dfcc_pkg::CMD_WRITE, 8'd0, 8'd0, 1'b1, '1, '0);
      send_word(dfcc_pkg::CMD_WRITE, 8'd255, 8'd255, 1'b1, '0, '1);
      send_word(dfcc_pkg::CMD_WRITE, 8'd255, 8'd0, 1'b0, $urandom, $urandom);
      send_word(dfcc_pkg::CMD_WRITE, 8'd0, 8'd255, 1'b1, $urandom, $urandom);
      send_word(dfcc_pkg::CMD_WRITE, 8'd128, 8'd128, 1'b1, $urandom, $urandom);
      query_cell(128, 128);   // free centre, blocked ring
      query_cell(4, 4);       // disk just reaches row 0 and column 0, all on the map
      query_cell(2, 128);     // off the map and blocked at once
      query_cell(253, 253);
      query_cell(255, 255);
      query_cell(0, 0);
      send_word(dfcc_pkg::CMD_QUERY, '1, '1, 1'b1, 32'h7FFF_FFFF, 32'h0000_0000);
      send_word(dfcc_pkg::CMD_QUERY, '0, '0, 1'b0, 32'h8000_0000, 32'h8000_0000);
      send_word(dfcc_pkg::CMD_QUERY, '1, '0, 1'b1, 32'h0000_0000, 32'h7FFF_FFFF);
      send_word(dfcc_pkg::CMD_QUERY, '0, '1, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // sum a hair below zero: truncation gives column 0, not -1
      send_word(dfcc_pkg::CMD_QUERY, 8'($urandom), 8'($urandom), 1'($urandom),
                -sb.x_off - 32'sd1, pos_for_cell(128, sb.y_off, sb.y_scale));
      send_word(dfcc_pkg::CMD_QUERY, 8'($urandom), 8'($urandom), 1'($urandom),
                pos_for_cell(128, sb.x_off, sb.x_scale), -sb.y_off - 32'sd1);
      // a whole unit below zero lands on a negative column
      send_word(dfcc_pkg::CMD_QUERY, 8'($urandom), 8'($urandom), 1'($urandom),
                -sb.x_off - 32'sh0001_0000, pos_for_cell(128, sb.y_off, sb.y_scale));
      wait_drained();

      // Unit scale, no offset: world units are cells
      sender_idle = 1;
      sink_stall  = 1;
      apply_config(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000);
      run_phase(300);

      // Reset values written back, no idling on either side
      sender_idle = 0;
      sink_stall  = 0;
      apply_config(dfcc_pkg::X_OFFSET_RST, dfcc_pkg::Y_OFFSET_RST,
                   {8'd0, dfcc_pkg::X_SCALE_RST}, {8'd0, dfcc_pkg::Y_SCALE_RST});
      run_phase(170);

      // Moderate random mapping
      sender_idle = 1;
      sink_stall  = 1;
      apply_config($signed($urandom_range(0, 32'h0050_0000)) - 32'sh0028_0000,
                   $signed($urandom_range(0, 32'h0050_0000)) - 32'sh0028_0000,
                   $urandom_range(32'h2000, 32'h4_0000), $urandom_range(32'h2000, 32'h4_0000));
      run_phase(250);

      // Extremes; also writes to indexes that decode to nothing
      apply_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h00FF_FFFF, 32'h0);
      write_register(CSR_NONE_LO, $urandom);
      write_register(CSR_NONE_HI, $urandom);
      run_phase(30);
      sender_idle = 0;
      apply_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF);
      run_phase(30);

      // Anything at all, upper bits of the scale words included
      sender_idle = 1'($urandom_range(0, 1));
      sink_stall  = 1;
      apply_config($urandom, $urandom, $urandom, $urandom);
      run_phase(80);

      // Zero scale: every query maps to the corner cell
      sender_idle = 1;
      apply_config($urandom, $urandom, 32'h0, 32'h0);
      run_phase(20);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.awaited_verdicts.size() == 0) begin
         $display("disk_footprint_collision_check test passed");
      end else begin
         if (sb.awaited_verdicts.size() != 0)
            $error("%0d verdicts never arrived", sb.awaited_verdicts.size());
         $display("disk_footprint_collision_check test failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/dfcc_pkg.sv
src/dfcc_ram.sv
src/disk_footprint_collision_check.sv
tb/sv/disk_footprint_collision_check_tb.sv
